FILE: src/hed_pkg.sv
// hed_pkg: shared constants, codes and types for the histogram distance block
// no dependencies
`default_nettype none

package hed_pkg;

  // default sizes handed to the top level
  localparam int NUM_STATES_DEF = 64;
  localparam int COUNT_BITS_DEF = 16;

  // fixed datapath widths (unsigned Q1.16 frequency, signed Q1.16 score)
  localparam int FREQ_W  = 17;
  localparam int SUM_W   = 34;
  localparam int SCORE_W = 18;
  localparam int LIM_W   = 9;
  localparam int SYM_W   = 8;

  localparam logic [FREQ_W-1:0] SCORE_FLOOR = 17'd92682;

  // register indexes
  localparam logic REG_MODE   = 1'b0;
  localparam logic REG_STATES = 1'b1;

  // mode codes
  localparam logic [1:0] MODE_RAW  = 2'd0;
  localparam logic [1:0] MODE_RUNS = 2'd1;

  // item kinds
  localparam logic [1:0] KIND_FIRST  = 2'd0;
  localparam logic [1:0] KIND_SECOND = 2'd1;
  localparam logic [1:0] KIND_FINISH = 2'd2;

  // shared iterative unit operation
  typedef enum logic {
    OP_DIV  = 1'b0,
    OP_SQRT = 1'b1
  } iter_op_t;

  typedef struct packed {
    logic     start;
    iter_op_t op;
  } iter_ctl_t;

  // sequencer states
  typedef enum logic [9:0] {
    ST_IDLE    = 10'b0000000001,
    ST_SYM_WR  = 10'b0000000010,
    ST_FIN_RD  = 10'b0000000100,
    ST_FIN_LAT = 10'b0000001000,
    ST_FIN_DA  = 10'b0000010000,
    ST_FIN_DB  = 10'b0000100000,
    ST_FIN_MUL = 10'b0001000000,
    ST_FIN_ACC = 10'b0010000000,
    ST_SQRT    = 10'b0100000000,
    ST_OUT     = 10'b1000000000
  } state_t;

endpackage

`default_nettype wire

FILE: src/histogram_euclidean_distance.sv
// histogram_euclidean_distance: a counted symbol item does a histogram ram read then
// a write; other symbol items keep the sequencer in idle. a finish item walks the
// first min(state_count, NUM_STATES) states, each with two 17-step divides in the
// shared unit, then a 17-step square root; with no states to walk, or a mode above
// runs, it goes straight to the output register, which may stall on out_tready.
// throughput: one item at a time; ready only in idle, result held in an output register.
// reset (synchronous, active low) clears control state, counts and ram valid bits.
`default_nettype none

module histogram_euclidean_distance
  import hed_pkg::*;
#(
  parameter int NUM_STATES = NUM_STATES_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input items
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] symbol
  input  wire logic [1:0]  in_tuser,   // [1:0] kind
  // result items
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [23:0] out_tdata,  // [17:0] score, [23:18] zero
  output logic      [0:0]  out_tuser,  // [0] flagged
  // configuration
  input  wire logic        cfg_we,
  input  wire logic        cfg_addr,
  input  wire logic [6:0]  cfg_wdata
);

  localparam int IDX_W = $clog2(NUM_STATES);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  state_t state_r, state_nxt;

  logic [1:0]            mode_r;
  logic [6:0]            states_r;
  logic [NUM_STATES-1:0] vld_a_r, vld_b_r;
  logic [COUNT_BITS-1:0] len_a_r, len_b_r;
  logic                  has_prev_a_r, has_prev_b_r;
  logic [SYM_W-1:0]      prev_a_r, prev_b_r;
  logic                  problem_r;
  logic                  sel_r;
  logic [IDX_W-1:0]      sym_r;
  logic [IDX_W-1:0]      idx_r;
  logic [COUNT_BITS-1:0] cnt_b_r;
  logic [FREQ_W-1:0]     fa_r, fb_r;
  logic [SUM_W-1:0]      prod_r, sum_r;
  logic [FREQ_W-1:0]     mag_r;
  logic                  out_valid_r;
  logic [SCORE_W-1:0]    out_score_r;
  logic                  out_flag_r;

  logic [COUNT_BITS-1:0] rdata_a, rdata_b;
  logic [IDX_W-1:0]      raddr;
  logic                  we_a, we_b;
  logic [COUNT_BITS-1:0] wdata;

  iter_ctl_t             ictl;
  logic [COUNT_BITS-1:0] inum, iden;
  logic [SUM_W-1:0]      irad;
  logic                  idone;
  logic [FREQ_W-1:0]     ires;

  logic [LIM_W-1:0]      lim;
  logic                  acc;
  logic [1:0]            kind;
  logic [SYM_W-1:0]      sym;
  logic                  in_sel;
  logic                  counted;
  logic                  in_range;
  logic [COUNT_BITS-1:0] cur;
  logic [COUNT_BITS-1:0] cur_len;
  logic [COUNT_BITS-1:0] cnt_a_rd, cnt_b_rd;
  logic [FREQ_W-1:0]     diff;
  logic [SUM_W-1:0]      sum_new;
  logic                  last;
  logic                  out_load;

  // input decode
  assign kind   = in_tuser;
  assign sym    = in_tdata;
  assign in_sel = kind[0];
  assign acc    = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);

  // states compared
  always_comb begin
    if (LIM_W'(states_r) > LIM_W'(NUM_STATES)) begin
      lim = LIM_W'(NUM_STATES);
    end else begin
      lim = LIM_W'(states_r);
    end
  end

  // run collapse and range check for a symbol item
  always_comb begin
    if (in_sel) begin
      counted = !(mode_r == MODE_RUNS && has_prev_b_r && prev_b_r == sym);
    end else begin
      counted = !(mode_r == MODE_RUNS && has_prev_a_r && prev_a_r == sym);
    end
    in_range = (LIM_W'(sym) < lim);
  end

  // histogram stores
  assign raddr = (state_r == ST_IDLE) ? sym[IDX_W-1:0] : idx_r;

  hed_ram #(.WIDTH(COUNT_BITS), .DEPTH(NUM_STATES)) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (sym_r),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata_a)
  );

  hed_ram #(.WIDTH(COUNT_BITS), .DEPTH(NUM_STATES)) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (sym_r),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata_b)
  );

  // saturating increment of the selected entry
  always_comb begin
    if (sel_r) begin
      cur     = vld_b_r[sym_r] ? rdata_b : '0;
      cur_len = len_b_r;
    end else begin
      cur     = vld_a_r[sym_r] ? rdata_a : '0;
      cur_len = len_a_r;
    end
    wdata = (cur == COUNT_MAX) ? cur : cur + COUNT_BITS'(1);
    we_a  = (state_r == ST_SYM_WR) && !sel_r;
    we_b  = (state_r == ST_SYM_WR) && sel_r;
  end

  // counts read during the walk, unwritten entries are zero
  assign cnt_a_rd = vld_a_r[idx_r] ? rdata_a : '0;
  assign cnt_b_rd = vld_b_r[idx_r] ? rdata_b : '0;

  // shared divide and root unit
  always_comb begin
    ictl = '{start: 1'b0, op: OP_DIV};
    inum = cnt_a_rd;
    iden = len_a_r;
    irad = sum_new;
    unique case (state_r)
      ST_FIN_LAT: ictl.start = 1'b1;
      ST_FIN_DA: begin
        ictl.start = idone;
        inum       = cnt_b_r;
        iden       = len_b_r;
      end
      ST_FIN_ACC: begin
        ictl.start = last;
        ictl.op    = OP_SQRT;
      end
      default: ;
    endcase
  end

  hed_iter #(.COUNT_BITS(COUNT_BITS)) u_iter (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ictl),
    .num    (inum),
    .den    (iden),
    .rad    (irad),
    .done   (idone),
    .result (ires)
  );

  assign diff    = (fa_r > fb_r) ? fa_r - fb_r : fb_r - fa_r;
  assign sum_new = sum_r + prod_r;
  assign last    = (LIM_W'(idx_r) == lim - LIM_W'(1));
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_tready);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          if ((kind == KIND_FIRST || kind == KIND_SECOND) && counted && in_range) begin
            state_nxt = ST_SYM_WR;
          end else if (kind == KIND_FINISH) begin
            if (mode_r > MODE_RUNS || lim == '0) begin
              state_nxt = ST_OUT;
            end else begin
              state_nxt = ST_FIN_RD;
            end
          end
        end
      end
      ST_SYM_WR:  state_nxt = ST_IDLE;
      ST_FIN_RD:  state_nxt = ST_FIN_LAT;
      ST_FIN_LAT: state_nxt = ST_FIN_DA;
      ST_FIN_DA:  if (idone) state_nxt = ST_FIN_DB;
      ST_FIN_DB:  if (idone) state_nxt = ST_FIN_MUL;
      ST_FIN_MUL: state_nxt = ST_FIN_ACC;
      ST_FIN_ACC: state_nxt = last ? ST_SQRT : ST_FIN_RD;
      ST_SQRT:    if (idone) state_nxt = ST_OUT;
      ST_OUT:     if (out_load) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // control state and stores
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      mode_r       <= MODE_RAW;
      states_r     <= 7'd64;
      vld_a_r      <= '0;
      vld_b_r      <= '0;
      len_a_r      <= '0;
      len_b_r      <= '0;
      has_prev_a_r <= 1'b0;
      has_prev_b_r <= 1'b0;
      problem_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // configuration writes
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_MODE:   mode_r   <= cfg_wdata[1:0];
          REG_STATES: states_r <= cfg_wdata;
          default: ;
        endcase
      end

      // symbol item: previous symbol and drop flag
      if (acc && (kind == KIND_FIRST || kind == KIND_SECOND)) begin
        if (in_sel) begin
          has_prev_b_r <= 1'b1;
        end else begin
          has_prev_a_r <= 1'b1;
        end
        if (counted && !in_range) begin
          problem_r <= 1'b1;
        end
      end

      // counted symbol update
      if (state_r == ST_SYM_WR) begin
        if (cur == COUNT_MAX || cur_len == COUNT_MAX) begin
          problem_r <= 1'b1;
        end
        if (sel_r) begin
          vld_b_r[sym_r] <= 1'b1;
          if (len_b_r != COUNT_MAX) len_b_r <= len_b_r + COUNT_BITS'(1);
        end else begin
          vld_a_r[sym_r] <= 1'b1;
          if (len_a_r != COUNT_MAX) len_a_r <= len_a_r + COUNT_BITS'(1);
        end
      end

      // result register
      if (out_load) begin
        out_valid_r  <= 1'b1;
        vld_a_r      <= '0;
        vld_b_r      <= '0;
        len_a_r      <= '0;
        len_b_r      <= '0;
        has_prev_a_r <= 1'b0;
        has_prev_b_r <= 1'b0;
        problem_r    <= 1'b0;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (acc) begin
      sel_r <= in_sel;
      sym_r <= sym[IDX_W-1:0];
      idx_r <= '0;
      sum_r <= '0;
      mag_r <= '0;
    end
    // previous symbol follows symbol items only
    if (acc && (kind == KIND_FIRST || kind == KIND_SECOND)) begin
      if (in_sel) begin
        prev_b_r <= sym;
      end else begin
        prev_a_r <= sym;
      end
    end
    if (state_r == ST_FIN_LAT) cnt_b_r <= cnt_b_rd;
    if (state_r == ST_FIN_DA && idone) fa_r <= (len_a_r == '0) ? '0 : ires;
    if (state_r == ST_FIN_DB && idone) fb_r <= (len_b_r == '0) ? '0 : ires;
    if (state_r == ST_FIN_MUL) prod_r <= SUM_W'(diff * diff);
    if (state_r == ST_FIN_ACC) begin
      sum_r <= sum_new;
      idx_r <= idx_r + IDX_W'(1);
    end
    if (state_r == ST_SQRT && idone) mag_r <= (ires > SCORE_FLOOR) ? SCORE_FLOOR : ires;
    if (out_load) begin
      out_score_r <= SCORE_W'(0) - SCORE_W'(mag_r);
      out_flag_r  <= problem_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_score_r};
  assign out_tuser  = out_flag_r;

  // ram writes only come from the symbol update step
  a_wr_state: assert property (@(posedge clk) disable iff (!rst_n)
    (we_a || we_b) |-> state_r == ST_SYM_WR)
    else $error("histogram write outside symbol update");

  // stores are empty after a result is loaded
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (len_a_r == '0 && len_b_r == '0 && !problem_r && vld_a_r == '0))
    else $error("stores not cleared after finish");

  // the shared unit only finishes while the walk waits for it
  a_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    idone |-> (state_r == ST_FIN_DA || state_r == ST_FIN_DB || state_r == ST_SQRT))
    else $error("unexpected completion of shared unit");

  // no item is taken while a finish is being scored
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SQRT || state_r == ST_FIN_DA) |-> !in_tready)
    else $error("input ready during scoring");

endmodule

`default_nettype wire

FILE: src/hed_ram.sv
// hed_ram: generic single write port ram with registered read
// no dependencies
`default_nettype none

module hed_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: src/hed_iter.sv
// hed_iter: shared iterative restoring unit, one quotient or root bit per cycle
// depends on hed_pkg
`default_nettype none

module hed_iter
  import hed_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire iter_ctl_t             ctl,
  input  wire logic [COUNT_BITS-1:0] num,
  input  wire logic [COUNT_BITS-1:0] den,
  input  wire logic [SUM_W-1:0]      rad,
  output logic                       done,
  output logic      [FREQ_W-1:0]     result
);

  localparam int SUB_W  = (COUNT_BITS + 2 > 21) ? COUNT_BITS + 2 : 21;
  localparam int STEP_W = $clog2(FREQ_W + 1);

  logic                  busy_r;
  logic                  done_r;
  iter_op_t              op_r;
  logic                  first_r;
  logic [STEP_W-1:0]     step_r;
  logic [SUB_W-1:0]      rem_r;
  logic [FREQ_W-1:0]     q_r;
  logic [SUM_W-1:0]      x_r;
  logic [COUNT_BITS-1:0] den_r;

  logic [SUB_W-1:0] cand;
  logic [SUB_W-1:0] trial;
  logic             ge;

  // shared compare and subtract: divisor or trial root
  always_comb begin
    if (op_r == OP_DIV) begin
      cand  = first_r ? rem_r : {rem_r[SUB_W-2:0], 1'b0};
      trial = SUB_W'(den_r);
    end else begin
      cand  = {rem_r[SUB_W-3:0], x_r[SUM_W-1 -: 2]};
      trial = SUB_W'({q_r, 2'b01});
    end
    ge = (cand >= trial);
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && step_r == STEP_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      op_r    <= ctl.op;
      first_r <= 1'b1;
      step_r  <= STEP_W'(FREQ_W);
      rem_r   <= (ctl.op == OP_DIV) ? SUB_W'(num) : '0;
      q_r     <= '0;
      x_r     <= rad;
      den_r   <= den;
    end else if (busy_r) begin
      first_r <= 1'b0;
      step_r  <= step_r - STEP_W'(1);
      rem_r   <= ge ? cand - trial : cand;
      q_r     <= {q_r[FREQ_W-2:0], ge};
      x_r     <= {x_r[SUM_W-3:0], 2'b00};
    end
  end

  assign done   = done_r;
  assign result = q_r;

endmodule

`default_nettype wire

FILE: sim/histogram_euclidean_distance_checker.sv
// histogram_euclidean_distance_checker: watches the input, result and configuration ports,
// predicts each score item and compares it with what the block sends
// depends on hed_pkg
`timescale 1ns / 100ps
`default_nettype none

module histogram_euclidean_distance_checker
  import hed_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [7:0]  in_tdata,
  input  wire logic [1:0]  in_tuser,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [23:0] out_tdata,
  input  wire logic [0:0]  out_tuser,
  input  wire logic        cfg_we,
  input  wire logic        cfg_addr,
  input  wire logic [6:0]  cfg_wdata,
  output int               fail_count,
  output int               pending_scores
);

  localparam int STATES = 64;
  localparam logic [15:0] COUNT_TOP = 16'hFFFF;

  typedef struct packed {
    logic [17:0] score;
    logic        flagged;
  } score_item_t;

  // predicted configuration and histogram state
  logic [1:0]  mode_q;
  logic [6:0]  states_q;
  logic [15:0] hist_a [STATES];
  logic [15:0] hist_b [STATES];
  logic [15:0] len_a, len_b;
  logic        prev_ok_a, prev_ok_b;
  logic [7:0]  prev_a, prev_b;
  logic        problem;
  score_item_t score_fifo [$];

  assign pending_scores = score_fifo.size();

  function automatic int active_states();
    return (states_q < STATES) ? int'(states_q) : STATES;
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [63:0] x);
    logic [63:0] root, bit_v;
    root = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > x) bit_v >>= 2;
    while (bit_v != 0) begin
      if (x >= root + bit_v) begin
        x -= root + bit_v;
        root = (root >> 1) + bit_v;
      end else begin
        root >>= 1;
      end
      bit_v >>= 2;
    end
    return root;
  endfunction

  function automatic logic [63:0] norm_freq(logic [15:0] cnt, logic [15:0] len);
    if (len == 0) return 0;
    return ({48'd0, cnt} << 16) / len;
  endfunction

  function automatic logic [63:0] hist_distance();
    logic [63:0] acc, fa, fb, diff;
    acc = 0;
    for (int i = 0; i < active_states(); i++) begin
      fa = norm_freq(hist_a[i], len_a);
      fb = norm_freq(hist_b[i], len_b);
      diff = (fa > fb) ? fa - fb : fb - fa;
      acc += diff * diff;
    end
    return floor_sqrt(acc);
  endfunction

  task automatic clear_hist();
    for (int i = 0; i < STATES; i++) begin
      hist_a[i] = 0;
      hist_b[i] = 0;
    end
    len_a = 0; len_b = 0;
    prev_ok_a = 0; prev_ok_b = 0;
    prev_a = 0; prev_b = 0;
    problem = 0;
  endtask

  function automatic logic [15:0] bump(logic [15:0] v);
    if (v == COUNT_TOP) begin
      problem = 1;
      return v;
    end
    return v + 1;
  endfunction

  // load one symbol into the selected sequence
  task automatic load_symbol(bit second, logic [7:0] sym);
    bit counted;
    counted = 1;
    if (!second) begin
      if (mode_q == MODE_RUNS && prev_ok_a && prev_a == sym) counted = 0;
      prev_ok_a = 1; prev_a = sym;
    end else begin
      if (mode_q == MODE_RUNS && prev_ok_b && prev_b == sym) counted = 0;
      prev_ok_b = 1; prev_b = sym;
    end
    if (!counted) return;
    if (int'(sym) >= active_states()) begin
      problem = 1;
      return;
    end
    if (!second) begin
      hist_a[sym] = bump(hist_a[sym]);
      len_a = bump(len_a);
    end else begin
      hist_b[sym] = bump(hist_b[sym]);
      len_b = bump(len_b);
    end
  endtask

  always @(posedge clk) begin
    score_item_t exp_item;
    logic [63:0] mag;
    int          errs;
    errs = 0;
    if (!rst_n) begin
      mode_q <= MODE_RAW;
      states_q <= 7'd64;
      clear_hist();
      score_fifo.delete();
      fail_count <= 0;
    end else begin
      // result side compare
      if (out_tvalid && out_tready) begin
        if (score_fifo.size() == 0) begin
          $display("%0t: unexpected result score=%h flagged=%b", $time,
                   out_tdata[17:0], out_tuser[0]);
          errs++;
        end else begin
          exp_item = score_fifo.pop_front();
          if (out_tdata[17:0] !== exp_item.score) begin
            $display("%0t: score mismatch expected %h actual %h", $time,
                     exp_item.score, out_tdata[17:0]);
            errs++;
          end
          if (out_tuser[0] !== exp_item.flagged) begin
            $display("%0t: flagged mismatch expected %b actual %b", $time,
                     exp_item.flagged, out_tuser[0]);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count <= fail_count + errs;
      // register writes
      if (cfg_we) begin
        if (cfg_addr == REG_MODE) mode_q <= cfg_wdata[1:0];
        else states_q <= cfg_wdata;
      end
      // input side prediction
      if (in_tvalid && in_tready) begin
        case (in_tuser)
          KIND_FIRST:  load_symbol(0, in_tdata);
          KIND_SECOND: load_symbol(1, in_tdata);
          KIND_FINISH: begin
            mag = (mode_q <= MODE_RUNS) ? hist_distance() : 64'd0;
            if (mag > 64'd92682) mag = 64'd92682;
            exp_item.score = 18'(-mag);
            exp_item.flagged = problem;
            score_fifo.push_back(exp_item);
            clear_hist();
          end
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

FILE: sim/histogram_euclidean_distance_tb.sv
// histogram_euclidean_distance_tb: drives symbol and finish items with random gaps,
// steps through register settings between phases; checking lives in the checker module
// depends on hed_pkg, histogram_euclidean_distance and histogram_euclidean_distance_checker
`timescale 1ns / 100ps
`default_nettype none

module histogram_euclidean_distance_tb;
  import hed_pkg::*;

  localparam int STALL_LIMIT = 200000;

  logic        clk, rst_n;
  logic        in_tvalid, in_tready;
  logic [7:0]  in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid, out_tready;
  logic [23:0] out_tdata;  // [17:0] score, [23:18] zero
  logic [0:0]  out_tuser;  // [0] flagged
  logic        cfg_we, cfg_addr;
  logic [6:0]  cfg_wdata;
  int          fail_count, pending_scores;
  int          idle_cycles;
  bit          calm;

  histogram_euclidean_distance u_top (.*);

  histogram_euclidean_distance_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver stalls at random except during calm stretches
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 0;
    else out_tready <= calm || ($urandom_range(99) >= 37);
  end

  // watchdog on accepted traffic
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // valid stays high after the accepting edge until the next item or an idle
  task automatic send_item(logic [1:0] kind, logic [7:0] sym);
    while (!calm && $urandom_range(99) < 37) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= kind;
    in_tdata <= sym;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain_scores();
    in_tvalid <= 0;
    while (pending_scores != 0) @(posedge clk);
    repeat (3000) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [6:0] val);
    in_tvalid <= 0;
    cfg_we <= 1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  // mostly in-range symbols, some out of range, some repeats for run collapse
  function automatic logic [7:0] pick_symbol(int lim, logic [7:0] last);
    int r;
    r = $urandom_range(99);
    if (r < 20) return last;
    if (r < 30) return 8'($urandom_range(255));
    return 8'($urandom_range((lim > 0) ? lim - 1 : 0));
  endfunction

  task automatic random_phase(int count, logic [1:0] mode, logic [6:0] states);
    logic [7:0] last;
    int lim, r;
    last = 0;
    lim = (states > 64) ? 64 : states;
    write_reg(REG_MODE, {5'd0, mode});
    write_reg(REG_STATES, states);
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 6) send_item(KIND_FINISH, 8'($urandom_range(255)));
      else if (r < 8) send_item(2'd3, 8'($urandom_range(255)));
      else begin
        last = pick_symbol(lim, last);
        send_item((r < 53) ? KIND_FIRST : KIND_SECOND, last);
      end
    end
    send_item(KIND_FINISH, 8'd0);
    drain_scores();
  endtask

  initial begin
    rst_n = 0;
    in_tvalid = 0; in_tdata = 0; in_tuser = 0;
    cfg_we = 0; cfg_addr = 0; cfg_wdata = 0;
    calm = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: empty finish, identical, disjoint, extremes, runs, kind 3
    send_item(KIND_FINISH, 8'hFF);
    send_item(KIND_FIRST, 8'd0);
    send_item(KIND_SECOND, 8'd0);
    send_item(KIND_FINISH, 8'd0);
    send_item(KIND_FIRST, 8'd0);
    send_item(KIND_SECOND, 8'd63);
    send_item(KIND_FINISH, 8'd0);
    send_item(KIND_FIRST, 8'd64);
    send_item(KIND_FIRST, 8'd255);
    send_item(KIND_SECOND, 8'd170);
    send_item(2'd3, 8'h55);
    send_item(KIND_SECOND, 8'd5);
    send_item(KIND_FINISH, 8'd0);
    drain_scores();
    write_reg(REG_MODE, {5'd0, MODE_RUNS});
    send_item(KIND_FIRST, 8'd3);
    send_item(KIND_FIRST, 8'd3);
    send_item(KIND_FIRST, 8'd200);
    send_item(KIND_FIRST, 8'd200);
    send_item(KIND_FIRST, 8'd3);
    send_item(KIND_SECOND, 8'd3);
    send_item(2'd3, 8'd9);
    send_item(KIND_SECOND, 8'd3);
    send_item(KIND_FINISH, 8'd0);
    drain_scores();
    write_reg(REG_MODE, 7'd2);
    send_item(KIND_FIRST, 8'd1);
    send_item(KIND_SECOND, 8'd2);
    send_item(KIND_FINISH, 8'd0);
    drain_scores();

    // random phases over several settings, one calm stretch
    random_phase(300, MODE_RAW, 7'd64);
    random_phase(250, MODE_RUNS, 7'd4);
    random_phase(150, MODE_RAW, 7'd0);
    calm = 1;
    random_phase(250, MODE_RAW, 7'd127);
    calm = 0;
    random_phase(200, MODE_RUNS, 7'd64);
    random_phase(150, 2'd3, 7'd16);
    random_phase(200, MODE_RAW, 7'd1);

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
